FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is applied.
`define APC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication from one cycle to the next, switched off while reset is applied.
`define APC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);

`endif

FILE: rtl/apc_pkg.sv
`timescale 1ns / 1ps
package apc_pkg;

  // Field widths
  localparam int AmtW = 63;
  localparam int IdW  = 32;
  localparam int ProdW = 126;

  // Status codes of a result
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_ZERODIV = 2'd2;
  localparam logic [1:0] ST_OVERRUN = 2'd3;

  // Supply limit after reset
  localparam logic [AmtW-1:0] MaxSupplyRst = 63'd1000000000000000;

  // Request details that travel alongside the arithmetic
  typedef struct packed {
    logic [1:0]     st;
    logic [IdW-1:0] tag;
  } apc_side_t;

  // Front-end payload carried through the multiplier
  typedef struct packed {
    logic            mode;
    logic [AmtW-1:0] d;
    apc_side_t       side;
  } apc_front_t;

  // One stage of the long division
  typedef struct packed {
    logic [AmtW-1:0] r;
    logic [AmtW-1:0] w;
    logic [AmtW-1:0] d;
    logic            big;
    apc_side_t       side;
  } apc_div_t;

endpackage

FILE: rtl/apc_mul.sv
`timescale 1ns / 1ps
module apc_mul import apc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [AmtW-1:0] a_i,
  input  logic [AmtW-1:0] b_i,
  input  apc_front_t      front_i,
  output logic            valid_o,
  output logic [ProdW-1:0] prod_o,
  output apc_front_t      front_o
);

  logic [2:0]  valid_q;
  logic [63:0] p00_q, p01_q, p10_q, p11_q;
  logic [64:0] mid_q;
  logic [ProdW-1:0] hilo_q;
  logic [ProdW-1:0] prod_q;
  apc_front_t  front1_q, front2_q, front3_q;
  logic [ProdW-1:0] prod_d;

  // Valid bits of the three multiplier stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // Final sum of the partial products
  assign prod_d = hilo_q + {29'd0, mid_q, 32'd0};

  // Stage one forms four partial products from the 32-bit low and 31-bit high halves,
  // stage two the middle sum and the joined outer products, stage three the full product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q    <= {32'd0, a_i[31:0]} * {32'd0, b_i[31:0]};
      p01_q    <= {32'd0, a_i[31:0]} * {33'd0, b_i[62:32]};
      p10_q    <= {33'd0, a_i[62:32]} * {32'd0, b_i[31:0]};
      p11_q    <= {33'd0, a_i[62:32]} * {33'd0, b_i[62:32]};
      front1_q <= front_i;
      mid_q    <= {1'b0, p01_q} + {1'b0, p10_q};
      hilo_q   <= {p11_q[61:0], p00_q};
      front2_q <= front1_q;
      prod_q   <= prod_d;
      front3_q <= front2_q;
    end
  end

  assign valid_o = valid_q[2];
  assign prod_o  = prod_q;
  assign front_o = front3_q;

endmodule

FILE: rtl/apc_div_step.sv
`timescale 1ns / 1ps
module apc_div_step import apc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  apc_div_t stage_i,
  output logic     valid_o,
  output apc_div_t stage_o
);

  logic            valid_q;
  apc_div_t        stage_q;
  apc_div_t        stage_d;
  logic [AmtW:0]   trial;
  logic [AmtW:0]   diff;
  logic            ge;

  // One restoring step: bring down the next numerator bit and subtract
  assign trial = {stage_i.r, stage_i.w[AmtW-1]};
  assign diff  = trial - {1'b0, stage_i.d};
  assign ge    = trial >= {1'b0, stage_i.d};

  always_comb begin
    stage_d   = stage_i;
    stage_d.r = ge ? diff[AmtW-1:0] : trial[AmtW-1:0];
    stage_d.w = {stage_i.w[AmtW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

FILE: rtl/asset_price_convert.sv
`timescale 1ns / 1ps
// A request is registered at the input, then passes the multiplier stages, the round-up
// and pre-division registers and the division stages into the output register.
// Throughput: one request per cycle while in_stall_o is low; the 63 one-bit division stages set the depth.
// A one-entry skid register behind the pipeline holds a result while the output stalls.
// Reset clears all valid bits and loads max_supply with 1000000000000000.
module asset_price_convert import apc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            max_supply_we_i,
  input  logic [AmtW-1:0] max_supply_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            mode_i,
  input  logic [AmtW-1:0] amount_i,
  input  logic [IdW-1:0]  amount_id_i,
  input  logic [AmtW-1:0] base_amount_i,
  input  logic [IdW-1:0]  base_id_i,
  input  logic [AmtW-1:0] quote_amount_i,
  input  logic [IdW-1:0]  quote_id_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [AmtW-1:0] result_amount_o,
  output logic [IdW-1:0]  result_id_o,
  output logic [1:0]      status_o
);

  logic [AmtW-1:0] max_supply_q;
  logic            en;

  // Supply limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_supply_q <= MaxSupplyRst;
    end else if (max_supply_we_i) begin
      max_supply_q <= max_supply_i;
    end
  end

  // Side selection
  logic            match_base, match_quote;
  logic [AmtW-1:0] mult_d, div_d;
  apc_front_t      front_d, front_q;
  logic [AmtW-1:0] amount_q, mult_q;
  logic            s0_valid_q;

  assign match_base  = amount_id_i == base_id_i;
  assign match_quote = amount_id_i == quote_id_i;
  assign mult_d      = match_base ? quote_amount_i : base_amount_i;
  assign div_d       = match_base ? base_amount_i : quote_amount_i;

  always_comb begin
    front_d.mode = mode_i;
    front_d.d    = div_d;
    if (match_base) begin
      front_d.side.tag = quote_id_i;
    end else if (match_quote) begin
      front_d.side.tag = base_id_i;
    end else begin
      front_d.side.tag = '0;
    end
    if (!(match_base || match_quote)) begin
      front_d.side.st = ST_NOMATCH;
    end else if (div_d == '0) begin
      front_d.side.st = ST_ZERODIV;
    end else begin
      front_d.side.st = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      amount_q <= amount_i;
      mult_q   <= mult_d;
      front_q  <= front_d;
    end
  end

  // Full product
  logic             mul_valid;
  logic [ProdW-1:0] mul_prod;
  apc_front_t       mul_front;

  apc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_valid_q),
    .a_i     (amount_q),
    .b_i     (mult_q),
    .front_i (front_q),
    .valid_o (mul_valid),
    .prod_o  (mul_prod),
    .front_o (mul_front)
  );

  // Round-up bias: add divisor minus one when mode asks for it
  logic             rnd_valid_q;
  logic [ProdW:0]   num_q;
  logic [AmtW-1:0]  rnd_d_q;
  apc_side_t        rnd_side_q;
  logic [AmtW-1:0]  bias;

  assign bias = mul_front.mode ? (mul_front.d - 63'd1) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_valid_q <= 1'b0;
    end else if (en) begin
      rnd_valid_q <= mul_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q      <= {1'b0, mul_prod} + {64'd0, bias};
      rnd_d_q    <= mul_front.d;
      rnd_side_q <= mul_front.side;
    end
  end

  // Upper numerator half against the divisor: a quotient of 2^63 or more is an overrun
  logic     pre_valid_q;
  apc_div_t pre_q, pre_d;
  logic     big;

  assign big = num_q[ProdW:AmtW] >= {1'b0, rnd_d_q};

  always_comb begin
    pre_d.r    = big ? '0 : num_q[ProdW-1:AmtW];
    pre_d.w    = num_q[AmtW-1:0];
    pre_d.d    = rnd_d_q;
    pre_d.big  = big;
    pre_d.side = rnd_side_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else if (en) begin
      pre_valid_q <= rnd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_q <= pre_d;
    end
  end

  // Long division, one quotient bit per stage
  logic     dv_valid [AmtW+1];
  apc_div_t dv_stage [AmtW+1];

  assign dv_valid[0] = pre_valid_q;
  assign dv_stage[0] = pre_q;

  for (genvar g = 0; g < AmtW; g++) begin : g_div
    apc_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[g]),
      .stage_i (dv_stage[g]),
      .valid_o (dv_valid[g+1]),
      .stage_o (dv_stage[g+1])
    );
  end

  // Status and result of the finished request
  apc_div_t        fin;
  logic            fin_valid;
  logic [1:0]      fin_st;
  logic [AmtW-1:0] fin_amt;

  assign fin       = dv_stage[AmtW];
  assign fin_valid = dv_valid[AmtW];

  always_comb begin
    fin_st = fin.side.st;
    if (fin.side.st == ST_OK && (fin.big || fin.w > max_supply_q)) begin
      fin_st = ST_OVERRUN;
    end
  end
  assign fin_amt = (fin_st == ST_OK) ? fin.w : '0;

  // Output register with one skid entry
  logic            out_valid_q, skid_valid_q, take;
  logic [AmtW-1:0] out_amt_q, skid_amt_q;
  logic [IdW-1:0]  out_id_q, skid_id_q;
  logic [1:0]      out_st_q, skid_st_q;

  assign en   = !skid_valid_q;
  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (fin_valid) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_amt_q <= skid_amt_q;
        out_id_q  <= skid_id_q;
        out_st_q  <= skid_st_q;
      end
    end else if (fin_valid) begin
      if (out_valid_q && !take) begin
        skid_amt_q <= fin_amt;
        skid_id_q  <= fin.side.tag;
        skid_st_q  <= fin_st;
      end else begin
        out_amt_q <= fin_amt;
        out_id_q  <= fin.side.tag;
        out_st_q  <= fin_st;
      end
    end
  end

  assign in_stall_o      = skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign result_amount_o = out_amt_q;
  assign result_id_o     = out_id_q;
  assign status_o        = out_st_q;

endmodule

FILE: rtl/apc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module apc_checker import apc_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            max_supply_we_i,
  input logic [AmtW-1:0] max_supply_i,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            mode_i,
  input logic [AmtW-1:0] amount_i,
  input logic [IdW-1:0]  amount_id_i,
  input logic [AmtW-1:0] base_amount_i,
  input logic [IdW-1:0]  base_id_i,
  input logic [AmtW-1:0] quote_amount_i,
  input logic [IdW-1:0]  quote_id_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [AmtW-1:0] result_amount_o,
  input logic [IdW-1:0]  result_id_o,
  input logic [1:0]      status_o
);

  // A stalled result keeps its amount and status on the port unchanged.
  `APC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(result_amount_o) && $stable(status_o), "stalled result changed")

  // Any error status carries a zero amount.
  `APC_ASSERT(a_err_zero, out_valid_o && status_o != ST_OK |-> result_amount_o == '0, "error with nonzero amount")

  // A request without a matching id has no result id.
  `APC_ASSERT(a_nomatch_id, out_valid_o && status_o == ST_NOMATCH |-> result_id_o == '0, "no match with nonzero id")

  // Input back-pressure only starts after the output has been held.
  `APC_ASSERT(a_stall_cause, $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i), "input stall without output stall")

endmodule

bind asset_price_convert apc_checker u_apc_checker (.*);

FILE: sim/tb_asset_price_convert.sv
`timescale 1ns / 1ps
module tb_asset_price_convert;
  import apc_pkg::*;

  localparam int LATENCY = 70;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic            mode;
    logic [AmtW-1:0] amount;
    logic [IdW-1:0]  amount_id;
    logic [AmtW-1:0] base_amount;
    logic [IdW-1:0]  base_id;
    logic [AmtW-1:0] quote_amount;
    logic [IdW-1:0]  quote_id;
  } request_t;

  typedef struct packed {
    logic [AmtW-1:0] amount;
    logic [IdW-1:0]  id;
    logic [1:0]      st;
  } conversion_t;

  logic            clk_i;
  logic            rst_ni;
  logic            max_supply_we_i;
  logic [AmtW-1:0] max_supply_i;
  logic            in_valid_i;
  logic            in_stall_o;
  request_t        req;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [AmtW-1:0] result_amount_o;
  logic [IdW-1:0]  result_id_o;
  logic [1:0]      status_o;

  asset_price_convert i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .max_supply_we_i (max_supply_we_i),
    .max_supply_i    (max_supply_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (req.mode),
    .amount_i        (req.amount),
    .amount_id_i     (req.amount_id),
    .base_amount_i   (req.base_amount),
    .base_id_i       (req.base_id),
    .quote_amount_i  (req.quote_amount),
    .quote_id_i      (req.quote_id),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_amount_o (result_amount_o),
    .result_id_o     (result_id_o),
    .status_o        (status_o)
  );

  // Model state and the queue of expected conversions.
  logic [AmtW-1:0] supply_limit;
  conversion_t     pending_conversions[$];
  int              n_errors;
  int              n_requests;
  int              n_results;
  int              n_status[4];
  int              idle_cycles;
  bit              throttle_en;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Predict the conversion of one request.
  function automatic conversion_t convert_price(request_t r);
    conversion_t     c;
    logic [AmtW-1:0] mult;
    logic [AmtW-1:0] divisor;
    logic [127:0]    product;
    logic [127:0]    quotient;
    c = '0;
    if (r.amount_id == r.base_id) begin
      mult = r.quote_amount;
      divisor = r.base_amount;
      c.id = r.quote_id;
    end else if (r.amount_id == r.quote_id) begin
      mult = r.base_amount;
      divisor = r.quote_amount;
      c.id = r.base_id;
    end else begin
      c.st = ST_NOMATCH;
      return c;
    end
    if (divisor == '0) begin
      c.st = ST_ZERODIV;
      return c;
    end
    product = 128'(r.amount) * 128'(mult);
    if (r.mode) product = product + 128'(divisor) - 128'd1;
    quotient = product / 128'(divisor);
    if (quotient > 128'(supply_limit)) begin
      c.st = ST_OVERRUN;
    end else begin
      c.st = ST_OK;
      c.amount = quotient[AmtW-1:0];
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [AmtW-1:0] got, logic [AmtW-1:0] want);
    n_errors++;
    $display("Mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
  endtask

  // Check every result leaving the block against the oldest prediction.
  initial begin
    conversion_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        n_results++;
        if (pending_conversions.size() == 0) begin
          report_mismatch("unexpected result", 63'(status_o), '0);
        end else begin
          want = pending_conversions.pop_front();
          n_status[want.st]++;
          if (status_o != want.st) report_mismatch("status", 63'(status_o), 63'(want.st));
          if (result_id_o != want.id) report_mismatch("id", 63'(result_id_o), 63'(want.id));
          if (result_amount_o != want.amount)
            report_mismatch("amount", result_amount_o, want.amount);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Output stall in random bursts.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (throttle_en && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Send one request, with an occasional gap beforehand.
  task automatic send_request(request_t r);
    if (throttle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_conversions.push_back(convert_price(r));
    n_requests++;
    @(negedge clk_i);
  endtask

  task automatic drain_and_idle();
    in_valid_i <= 1'b0;
    while (pending_conversions.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  task automatic write_supply_limit(logic [AmtW-1:0] value);
    drain_and_idle();
    max_supply_we_i <= 1'b1;
    max_supply_i <= value;
    @(negedge clk_i);
    max_supply_we_i <= 1'b0;
    supply_limit = value;
  endtask

  function automatic logic [AmtW-1:0] rand_amount();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 63'($urandom_range(0, 1000));
      3: return 63'({$urandom(), $urandom()});
      4: return 63'($urandom()) << $urandom_range(0, 31);
      default: return 63'({$urandom(), $urandom()}) >> $urandom_range(0, 62);
    endcase
  endfunction

  // Mostly matching requests; sometimes no match, both match or a zero divisor.
  function automatic request_t rand_request();
    request_t r;
    r.mode = 1'($urandom());
    r.amount = rand_amount();
    r.base_amount = rand_amount();
    r.quote_amount = rand_amount();
    r.base_id = $urandom();
    r.quote_id = ($urandom_range(0, 15) == 0) ? r.base_id : $urandom();
    case ($urandom_range(0, 9))
      0: r.amount_id = $urandom();
      1, 2, 3, 4: r.amount_id = r.base_id;
      default: r.amount_id = r.quote_id;
    endcase
    return r;
  endfunction

  // Extremes of fields, both directions, both modes and every status.
  task automatic test_directed();
    request_t r;
    r = '{mode: 1'b0, amount: 63'd10, amount_id: 32'd5, base_amount: 63'd3, base_id: 32'd5,
          quote_amount: 63'd7, quote_id: 32'hFFFF_FFFF};
    send_request(r);
    r.mode = 1'b1;
    send_request(r);
    r.amount_id = 32'hFFFF_FFFF;
    send_request(r);
    r.mode = 1'b0;
    send_request(r);
    r.amount_id = 32'd0;
    send_request(r);
    r.quote_id = 32'd5;
    r.amount_id = 32'd5;
    send_request(r);
    r.base_amount = '0;
    send_request(r);
    r.base_id = 32'd9;
    r.quote_amount = '0;
    send_request(r);
    r = '{mode: 1'b0, amount: '1, amount_id: '1, base_amount: 63'd1, base_id: '1,
          quote_amount: '1, quote_id: '0};
    send_request(r);
    r.mode = 1'b1;
    send_request(r);
    r.base_amount = '1;
    send_request(r);
    r.mode = 1'b0;
    send_request(r);
    r.quote_amount = 63'd1;
    send_request(r);
    r.mode = 1'b1;
    send_request(r);
    r = '{mode: 1'b0, amount: 63'd1000000000000000, amount_id: '0, base_amount: 63'd1,
          base_id: '0, quote_amount: 63'd1, quote_id: 32'd1};
    send_request(r);
    r.amount = 63'd1000000000000001;
    send_request(r);
    r.amount = '0;
    send_request(r);
    r.mode = 1'b1;
    send_request(r);
  endtask

  task automatic test_supply_limits();
    request_t r;
    write_supply_limit('0);
    r = '{mode: 1'b0, amount: 63'd0, amount_id: 32'd1, base_amount: 63'd4, base_id: 32'd1,
          quote_amount: 63'd3, quote_id: 32'd2};
    send_request(r);
    r.amount = 63'd1;
    send_request(r);
    r.mode = 1'b1;
    send_request(r);
    write_supply_limit('1);
    r = '{mode: 1'b1, amount: '1, amount_id: 32'd1, base_amount: 63'd2, base_id: 32'd1,
          quote_amount: 63'd2, quote_id: 32'd2};
    send_request(r);
    r.base_amount = 63'd1;
    send_request(r);
  endtask

  task automatic test_random(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 200 == 199) begin
        case ($urandom_range(0, 3))
          0: write_supply_limit(63'($urandom_range(0, 1000000)));
          1: write_supply_limit('1);
          2: write_supply_limit(63'({$urandom(), $urandom()}));
          default: write_supply_limit(63'd1);
        endcase
      end
      send_request(rand_request());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    max_supply_we_i = 1'b0;
    max_supply_i = '0;
    in_valid_i = 1'b0;
    req = '0;
    supply_limit = MaxSupplyRst;
    n_errors = 0;
    n_requests = 0;
    n_results = 0;
    throttle_en = 1'b1;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_supply_limits();
    write_supply_limit(MaxSupplyRst);
    test_random(800);
    // Final stretch at full rate on both sides.
    throttle_en = 1'b0;
    test_random(120);

    drain_and_idle();
    $display("Run covered %0d requests and %0d results over several supply limits.",
             n_requests, n_results);
    $display("Statuses seen: ok %0d, no match %0d, zero divisor %0d, over limit %0d.",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
